FILE: src/ppa_pkg.sv
// Package for the per-CPU page allocator with stealing.
// Holds sizes, codes, the state type and small helpers shared by the link table and the top level.
package ppa_pkg;

    localparam int NUM_CPUS   = 8;
    localparam int NUM_PAGES  = 32768;
    localparam int PAGE_BYTES = 4096;

    localparam int ADDR_W     = 32;
    localparam int CPU_W      = 3;
    localparam int LINK_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int IDX_W      = $clog2(NUM_PAGES);
    localparam int CPU_IDX_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int STEP_W     = $clog2(NUM_PAGES + 1);

    localparam int IN_CMD_BIT  = 0;
    localparam int IN_CPU_LSB  = 1;
    localparam int IN_ADDR_LSB = IN_CPU_LSB + CPU_W;
    localparam int IN_DATA_W   = ((IN_ADDR_LSB + ADDR_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((ADDR_W + STATUS_W + 7) / 8) * 8;

    typedef logic [LINK_W-1:0]    t_link;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CPU_IDX_W-1:0] t_cpu;

    localparam t_link NIL = '1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_OOM      = 2'd1,
        ST_BAD_FREE = 2'd2
    } t_status;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic {
        CFG_REGION_START = 1'b0,
        CFG_REGION_END   = 1'b1
    } t_cfg_index;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POP,
        S_SCAN,
        S_FAST0,
        S_CHECK,
        S_FAST1,
        S_SLOW,
        S_FAST2,
        S_CUT,
        S_CUTW,
        S_GOTR,
        S_GOTD,
        S_RESP
    } t_state;

    typedef struct packed {
        logic  rd_en;
        t_link rd_addr;
        logic  wr_en;
        t_idx  wr_addr;
        t_link wr_data;
    } t_mem_req;

    function automatic logic link_valid(t_link l);
        return l < LINK_W'(NUM_PAGES);
    endfunction

    function automatic t_cpu fold_cpu(logic [CPU_W-1:0] c);
        logic [CPU_W:0] r;
        r = {1'b0, c};
        for (int k = 0; k < (1 << CPU_W); k++) begin
            if (r >= (CPU_W + 1)'(NUM_CPUS)) begin
                r = r - (CPU_W + 1)'(NUM_CPUS);
            end
        end
        return t_cpu'(r);
    endfunction

endpackage

FILE: src/ppa_link_mem.sv
// Shared link table of the page allocator: one write and one registered read per cycle.
// Depends on ppa_pkg; a read of an empty marker or of an out-of-range link returns the marker.
module ppa_link_mem (
    input  logic              i_clk,
    input  ppa_pkg::t_mem_req i_req,
    output ppa_pkg::t_link    o_link
);
    import ppa_pkg::*;

    t_link r_mem [NUM_PAGES];
    t_link r_rd_data;
    logic  r_rd_nil;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr[IDX_W-1:0]];
            r_rd_nil  <= !link_valid(i_req.rd_addr);
        end
    end

    assign o_link = (r_rd_nil || !link_valid(r_rd_data)) ? NIL : r_rd_data;

endmodule

FILE: src/per_cpu_page_allocator_with_steal.sv
// Top level of the per-CPU page allocator with stealing.
// Depends on ppa_pkg and ppa_link_mem.
//
// The block keeps one LIFO free list per CPU in a shared link table and answers
// every request item with one result item. A free goes from acceptance through
// the decode and response states to the result register, and an alloc served
// from its own list also passes the pop state; the next item can be taken in
// the cycle after the result is loaded. An alloc on an empty list scans the
// other CPUs one per cycle and then walks the victim list through the single
// read port of the link table, three reads for every two pages. The block
// takes no new item while one is in progress, but it does accept the next item
// while the previous result still waits in the output register.
module per_cpu_page_allocator_with_steal (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // Fields from bit 0: command, cpu[2:0], page_address[31:0], zero fill.
    input  logic [ppa_pkg::IN_DATA_W-1:0]  i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // Fields from bit 0: granted_address[31:0], status[1:0], zero fill.
    output logic [ppa_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [ppa_pkg::ADDR_W-1:0]     i_cfg_data
);
    import ppa_pkg::*;

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    t_cpu              r_cpu, n_cpu;
    logic [ADDR_W-1:0] r_addr, n_addr;
    t_cpu              r_victim, n_victim;
    t_link             r_got, n_got;
    t_link             r_slow, n_slow;
    t_link             r_fast, n_fast;
    logic [STEP_W-1:0] r_steps, n_steps;
    t_status           r_status, n_status;
    logic              r_out_valid, n_out_valid;
    logic [ADDR_W-1:0] r_out_addr, n_out_addr;
    t_status           r_out_status, n_out_status;

    logic [ADDR_W-1:0] r_region_start;
    logic [ADDR_W-1:0] r_region_end;
    logic [ADDR_W-1:0] r_base;

    t_link             r_head [NUM_CPUS];
    t_cpu              head_sel;
    t_link             head_rd;
    logic              head_we;
    t_cpu              head_wa;
    t_link             head_wd;

    t_mem_req          mem_req;
    t_link             mem_link;

    logic [ADDR_W-1:0] diff;
    logic              free_bad;

    ppa_link_mem u_link_mem (
        .i_clk  (i_clk),
        .i_req  (mem_req),
        .o_link (mem_link)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_start <= '0;
            r_region_end   <= '0;
            r_base         <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_REGION_START: begin
                    r_region_start <= i_cfg_data;
                    r_base <= (i_cfg_data + ADDR_W'(PAGE_BYTES - 1))
                              & ~ADDR_W'(PAGE_BYTES - 1);
                end
                CFG_REGION_END: begin
                    r_region_end <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign head_sel = (r_state == S_SCAN) ? r_victim : r_cpu;
    assign head_rd  = r_head[head_sel];

    assign diff     = r_addr - r_base;
    assign free_bad = (r_addr[PAGE_SHIFT-1:0] != '0) || (r_addr < r_region_start)
                      || (r_addr >= r_region_end)
                      || ((diff >> PAGE_SHIFT) >= ADDR_W'(NUM_PAGES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CPUS; k++) begin
                r_head[k] <= NIL;
            end
        end else if (head_we) begin
            r_head[head_wa] <= head_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_cmd        <= n_cmd;
        r_cpu        <= n_cpu;
        r_addr       <= n_addr;
        r_victim     <= n_victim;
        r_got        <= n_got;
        r_slow       <= n_slow;
        r_fast       <= n_fast;
        r_steps      <= n_steps;
        r_status     <= n_status;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_cpu        = r_cpu;
        n_addr       = r_addr;
        n_victim     = r_victim;
        n_got        = r_got;
        n_slow       = r_slow;
        n_fast       = r_fast;
        n_steps      = r_steps;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        o_s_tready   = 1'b0;
        head_we      = 1'b0;
        head_wa      = r_cpu;
        head_wd      = NIL;
        mem_req      = '0;

        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_cmd   = t_cmd'(i_s_tdata[IN_CMD_BIT]);
                    n_cpu   = fold_cpu(i_s_tdata[IN_CPU_LSB +: CPU_W]);
                    n_addr  = i_s_tdata[IN_ADDR_LSB +: ADDR_W];
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_status = ST_OK;
                if (r_cmd == CMD_FREE) begin
                    if (free_bad) begin
                        n_status = ST_BAD_FREE;
                    end else begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = diff[PAGE_SHIFT +: IDX_W];
                        mem_req.wr_data = link_valid(head_rd) ? head_rd : NIL;
                        head_we = 1'b1;
                        head_wd = LINK_W'(diff[PAGE_SHIFT +: IDX_W]);
                    end
                    n_state = S_RESP;
                end else if (link_valid(head_rd)) begin
                    n_got           = head_rd;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = head_rd;
                    n_state         = S_POP;
                end else begin
                    head_we  = 1'b1;
                    head_wd  = NIL;
                    n_victim = '0;
                    n_state  = S_SCAN;
                end
            end
            S_POP: begin
                head_we = 1'b1;
                head_wd = mem_link;
                n_state = S_RESP;
            end
            S_SCAN: begin
                if (r_victim != r_cpu && link_valid(head_rd)) begin
                    n_got           = head_rd;
                    n_slow          = head_rd;
                    n_steps         = '0;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = head_rd;
                    n_state         = S_FAST0;
                end else if (r_victim == CPU_IDX_W'(NUM_CPUS - 1)) begin
                    n_status = ST_OOM;
                    n_state  = S_RESP;
                end else begin
                    n_victim = r_victim + 1'b1;
                end
            end
            S_FAST0: begin
                n_fast  = mem_link;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!link_valid(r_fast) || r_steps == STEP_W'(NUM_PAGES)) begin
                    n_state = S_CUT;
                end else begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = r_fast;
                    n_state         = S_FAST1;
                end
            end
            S_FAST1: begin
                if (!link_valid(mem_link)) begin
                    n_state = S_CUT;
                end else begin
                    n_fast          = mem_link;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = r_slow;
                    n_state         = S_SLOW;
                end
            end
            S_SLOW: begin
                n_slow          = mem_link;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = r_fast;
                n_state         = S_FAST2;
            end
            S_FAST2: begin
                n_fast  = mem_link;
                n_steps = r_steps + 1'b1;
                n_state = S_CHECK;
            end
            S_CUT: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = r_slow;
                n_state         = S_CUTW;
            end
            S_CUTW: begin
                head_we = 1'b1;
                head_wa = r_victim;
                head_wd = mem_link;
                if (link_valid(r_slow)) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = r_slow[IDX_W-1:0];
                    mem_req.wr_data = NIL;
                end
                n_state = S_GOTR;
            end
            S_GOTR: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = r_got;
                n_state         = S_GOTD;
            end
            S_GOTD: begin
                head_we  = 1'b1;
                head_wd  = mem_link;
                n_status = ST_OK;
                n_state  = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    if (r_cmd == CMD_ALLOC && r_status == ST_OK) begin
                        n_out_addr = r_base + (ADDR_W'(r_got[IDX_W-1:0]) << PAGE_SHIFT);
                    end else begin
                        n_out_addr = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_DATA_W - ADDR_W - STATUS_W)'(0), r_out_status, r_out_addr};

endmodule
